// ----- rtl/sacs_pkg.sv -----
// Shared types and constants for the suffix automaton common substring core.
package sacs_pkg;

  // Default sizing of the reference string and the alphabet.
  localparam int MAX_LEN_DEF  = 4096;
  localparam int ALPHABET_DEF = 26;

  // Width of the reported length fields.
  localparam int LEN_OUT_W = 13;

  // Action codes of an input transaction.
  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_QUERY   = 2'd3
  } action_t;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0] action;
    logic [4:0] symbol;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [LEN_OUT_W-1:0] match_length;
    logic [LEN_OUT_W-1:0] best_length;
    logic                 reference_full;
  } out_t;

endpackage

// ----- rtl/sacs_trans_mem.sv -----
// Transition table memory: one entry per node and symbol, holding the target node.
module sacs_trans_mem #(
  parameter int NODE_W = 13,
  parameter int SYM_W  = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [NODE_W-1:0] wnode,
  input  logic [SYM_W-1:0]  wsym,
  input  logic [NODE_W-1:0] wdata,
  input  logic [NODE_W-1:0] rnode,
  input  logic [SYM_W-1:0]  rsym,
  output logic [NODE_W-1:0] rdata
);

  localparam int DEPTH = 1 << (NODE_W + SYM_W);

  logic [NODE_W-1:0] mem [DEPTH];

  // Rows are addressed by node with the symbol in the low bits.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[{wnode, wsym}] <= wdata;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rdata <= mem[{rnode, rsym}];
  end

endmodule

// ----- rtl/sacs_node_mem.sv -----
// Node memory: suffix link and node length for every automaton node.
module sacs_node_mem #(
  parameter int NODE_W = 13,
  parameter int LEN_W  = 13
) (
  input  logic              clk,
  input  logic              we,
  input  logic [NODE_W-1:0] waddr,
  input  logic [NODE_W-1:0] wlink,
  input  logic [LEN_W-1:0]  wlen,
  input  logic [NODE_W-1:0] raddr,
  output logic [NODE_W-1:0] rlink,
  output logic [LEN_W-1:0]  rlen
);

  localparam int DEPTH = 1 << NODE_W;

  logic [NODE_W+LEN_W-1:0] mem [DEPTH];
  logic [NODE_W+LEN_W-1:0] rword;

  // Link and length share one word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wlink, wlen};
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rword <= mem[raddr];
  end

  assign rlink = rword[NODE_W+LEN_W-1:LEN_W];
  assign rlen  = rword[LEN_W-1:0];

endmodule

// ----- rtl/sacs_ctrl.sv -----
// Sequencer that builds the automaton and runs the matcher over the two memories.
module sacs_ctrl #(
  parameter int MAX_LEN  = sacs_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = sacs_pkg::ALPHABET_DEF,
  parameter int NODE_W   = $clog2(2 * MAX_LEN),
  parameter int LEN_W    = $clog2(MAX_LEN + 1),
  parameter int SYM_W    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input channel.
  input  logic              in_valid,
  output logic              in_stall,
  input  sacs_pkg::in_t     in_data,
  // Result channel.
  output logic              out_valid,
  input  logic              out_stall,
  output sacs_pkg::out_t    out_data,
  // Transition memory port.
  output logic              tr_we,
  output logic [NODE_W-1:0] tr_wnode,
  output logic [SYM_W-1:0]  tr_wsym,
  output logic [NODE_W-1:0] tr_wdata,
  output logic [NODE_W-1:0] tr_rnode,
  output logic [SYM_W-1:0]  tr_rsym,
  input  logic [NODE_W-1:0] tr_rdata,
  // Node memory port.
  output logic              nd_we,
  output logic [NODE_W-1:0] nd_waddr,
  output logic [NODE_W-1:0] nd_wlink,
  output logic [LEN_W-1:0]  nd_wlen,
  output logic [NODE_W-1:0] nd_raddr,
  input  logic [NODE_W-1:0] nd_rlink,
  input  logic [LEN_W-1:0]  nd_rlen
);

  localparam int K_W = $clog2(ALPHABET + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ZERO, S_WRD, S_WCHK, S_FRD, S_FCHK,
    S_COPY, S_CLN, S_RRD, S_RCHK, S_QRD, S_QCHK, S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] node_cnt_r, node_cnt_nxt;
  logic [NODE_W-1:0] last_r, last_nxt;
  logic [LEN_W-1:0]  ref_len_r, ref_len_nxt;
  logic [NODE_W-1:0] match_r, match_nxt;
  logic [LEN_W-1:0]  cur_r, cur_nxt;
  logic [LEN_W-1:0]  best_r, best_nxt;
  logic              full_r, full_nxt;
  logic              emit_r, emit_nxt;
  logic              first_r, first_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [NODE_W-1:0] np_r, np_nxt;
  logic [NODE_W-1:0] p_r, p_nxt;
  logic [NODE_W-1:0] q_r, q_nxt;
  logic [NODE_W-1:0] qlink_r, qlink_nxt;
  logic [LEN_W-1:0]  len_p_r, len_p_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  sacs_pkg::out_t    out_data_r, out_data_nxt;

  logic [NODE_W-1:0] nq;
  logic [LEN_W-1:0]  len_p;
  logic [LEN_W-1:0]  new_cur;
  logic [K_W-1:0]    k_prev;
  logic              sym_ok;
  logic              accept;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The clone always takes the node number right after the new node.
  assign nq     = np_r + NODE_W'(1);
  // The root has length zero; its memory word is never written.
  assign len_p  = (p_r == '0) ? '0 : nd_rlen;
  assign k_prev = k_r - K_W'(1);
  assign sym_ok = (32'(in_data.symbol) < ALPHABET);

  // Next-state and memory control.
  always_comb begin
    state_nxt     = state_r;
    node_cnt_nxt  = node_cnt_r;
    last_nxt      = last_r;
    ref_len_nxt   = ref_len_r;
    match_nxt     = match_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    full_nxt      = full_r;
    emit_nxt      = emit_r;
    first_nxt     = first_r;
    sym_nxt       = sym_r;
    np_nxt        = np_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    qlink_nxt     = qlink_r;
    len_p_nxt     = len_p_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    new_cur       = '0;

    tr_we    = 1'b0;
    tr_wnode = np_r;
    tr_wsym  = k_r[SYM_W-1:0];
    tr_wdata = '0;
    tr_rnode = p_r;
    tr_rsym  = sym_r;
    nd_we    = 1'b0;
    nd_waddr = np_r;
    nd_wlink = '0;
    nd_wlen  = ref_len_r + LEN_W'(1);
    nd_raddr = p_r;

    // The result register drains independently of the sequencer.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // Zero the root row, one entry a cycle.
      S_CLR: begin
        tr_we    = 1'b1;
        tr_wnode = '0;
        k_nxt    = k_r + K_W'(1);
        if (32'(k_r) == ALPHABET - 1) begin
          state_nxt = emit_r ? S_DONE : S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          full_nxt = 1'b0;
          sym_nxt  = SYM_W'(in_data.symbol);
          k_nxt    = '0;
          case (in_data.action)
            sacs_pkg::ACT_CLEAR: begin
              node_cnt_nxt = NODE_W'(1);
              last_nxt     = '0;
              ref_len_nxt  = '0;
              match_nxt    = '0;
              cur_nxt      = '0;
              best_nxt     = '0;
              emit_nxt     = 1'b1;
              state_nxt    = S_CLR;
            end
            sacs_pkg::ACT_APPEND: begin
              if (ref_len_r >= LEN_W'(MAX_LEN)) begin
                full_nxt  = 1'b1;
                state_nxt = S_DONE;
              end else if (sym_ok) begin
                np_nxt    = node_cnt_r;
                p_nxt     = last_r;
                state_nxt = S_ZERO;
              end else begin
                state_nxt = S_DONE;
              end
            end
            sacs_pkg::ACT_RESTART: begin
              match_nxt = '0;
              cur_nxt   = '0;
              best_nxt  = '0;
              state_nxt = S_DONE;
            end
            default: begin
              if (sym_ok) begin
                p_nxt     = match_r;
                first_nxt = 1'b1;
                state_nxt = S_QRD;
              end else begin
                match_nxt = '0;
                cur_nxt   = '0;
                state_nxt = S_DONE;
              end
            end
          endcase
        end
      end

      // Clear the row of the new node.
      S_ZERO: begin
        tr_we    = 1'b1;
        tr_wnode = np_r;
        k_nxt    = k_r + K_W'(1);
        if (32'(k_r) == ALPHABET - 1) begin
          state_nxt = S_WRD;
        end
      end

      // First walk: add edges to the new node until one already exists.
      S_WRD: begin
        state_nxt = S_WCHK;
      end

      S_WCHK: begin
        if (tr_rdata != '0) begin
          q_nxt     = tr_rdata;
          len_p_nxt = len_p;
          state_nxt = S_FRD;
        end else begin
          tr_we    = 1'b1;
          tr_wnode = p_r;
          tr_wsym  = sym_r;
          tr_wdata = np_r;
          if (p_r == '0) begin
            nd_we        = 1'b1;
            nd_wlink     = '0;
            node_cnt_nxt = node_cnt_r + NODE_W'(1);
            last_nxt     = np_r;
            ref_len_nxt  = ref_len_r + LEN_W'(1);
            state_nxt    = S_DONE;
          end else begin
            p_nxt     = nd_rlink;
            state_nxt = S_WRD;
          end
        end
      end

      // Fetch the length of the existing target.
      S_FRD: begin
        nd_raddr  = q_r;
        state_nxt = S_FCHK;
      end

      S_FCHK: begin
        if ((len_p_r + LEN_W'(1)) == nd_rlen) begin
          // Solid transition: link the new node to it.
          nd_we        = 1'b1;
          nd_wlink     = q_r;
          node_cnt_nxt = node_cnt_r + NODE_W'(1);
          last_nxt     = np_r;
          ref_len_nxt  = ref_len_r + LEN_W'(1);
          state_nxt    = S_DONE;
        end else begin
          // Clone: the target keeps its length and now links to the clone.
          qlink_nxt = nd_rlink;
          nd_we     = 1'b1;
          nd_waddr  = q_r;
          nd_wlink  = nq;
          nd_wlen   = nd_rlen;
          k_nxt     = '0;
          state_nxt = S_COPY;
        end
      end

      // Copy the target's row to the clone, read one entry, write the one before.
      S_COPY: begin
        tr_rnode = q_r;
        tr_rsym  = k_r[SYM_W-1:0];
        tr_wnode = nq;
        tr_wsym  = k_prev[SYM_W-1:0];
        tr_wdata = tr_rdata;
        tr_we    = (k_r != '0);
        k_nxt    = k_r + K_W'(1);
        if (k_r == '0) begin
          nd_we    = 1'b1;
          nd_wlink = nq;
        end
        if (32'(k_r) == ALPHABET) begin
          state_nxt = S_CLN;
        end
      end

      // Store the clone's link and length.
      S_CLN: begin
        nd_we     = 1'b1;
        nd_waddr  = nq;
        nd_wlink  = qlink_r;
        nd_wlen   = len_p_r + LEN_W'(1);
        state_nxt = S_RRD;
      end

      // Second walk: redirect edges from the old target to the clone.
      S_RRD: begin
        state_nxt = S_RCHK;
      end

      S_RCHK: begin
        if (tr_rdata != q_r) begin
          node_cnt_nxt = node_cnt_r + NODE_W'(2);
          last_nxt     = np_r;
          ref_len_nxt  = ref_len_r + LEN_W'(1);
          state_nxt    = S_DONE;
        end else begin
          tr_we    = 1'b1;
          tr_wnode = p_r;
          tr_wsym  = sym_r;
          tr_wdata = nq;
          if (p_r == '0) begin
            node_cnt_nxt = node_cnt_r + NODE_W'(2);
            last_nxt     = np_r;
            ref_len_nxt  = ref_len_r + LEN_W'(1);
            state_nxt    = S_DONE;
          end else begin
            p_nxt     = nd_rlink;
            state_nxt = S_RRD;
          end
        end
      end

      // Matcher: follow the edge or fall back along suffix links.
      S_QRD: begin
        state_nxt = S_QCHK;
      end

      S_QCHK: begin
        if (tr_rdata != '0) begin
          new_cur   = first_r ? (cur_r + LEN_W'(1)) : (len_p + LEN_W'(1));
          cur_nxt   = new_cur;
          match_nxt = tr_rdata;
          if (new_cur > best_r) begin
            best_nxt = new_cur;
          end
          state_nxt = S_DONE;
        end else if (p_r == '0) begin
          match_nxt = '0;
          cur_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          p_nxt     = nd_rlink;
          first_nxt = 1'b0;
          state_nxt = S_QRD;
        end
      end

      // Hand the result over once the result register is free.
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.match_length   = sacs_pkg::LEN_OUT_W'(cur_r);
          out_data_nxt.best_length    = sacs_pkg::LEN_OUT_W'(best_r);
          out_data_nxt.reference_full = full_r;
          emit_nxt                    = 1'b0;
          state_nxt                   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      node_cnt_r  <= NODE_W'(1);
      last_r      <= '0;
      ref_len_r   <= '0;
      match_r     <= '0;
      cur_r       <= '0;
      best_r      <= '0;
      full_r      <= 1'b0;
      emit_r      <= 1'b0;
      first_r     <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      node_cnt_r  <= node_cnt_nxt;
      last_r      <= last_nxt;
      ref_len_r   <= ref_len_nxt;
      match_r     <= match_nxt;
      cur_r       <= cur_nxt;
      best_r      <= best_nxt;
      full_r      <= full_nxt;
      emit_r      <= emit_nxt;
      first_r     <= first_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sym_r      <= sym_nxt;
    np_r       <= np_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    qlink_r    <= qlink_nxt;
    len_p_r    <= len_p_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- rtl/suffix_automaton_common_substring_core.sv -----
// Top level of the suffix automaton common substring core.
//
// The core builds a suffix automaton over a reference string one symbol per
// append transaction and matches query symbols against it, giving one result
// transaction per input transaction. Work is done one transaction at a time
// by a sequencer around two memories with one write port and one registered
// read port each (transitions, and suffix link plus length per node). A query
// follows the edge for its symbol and falls back along suffix links until an
// edge is found or the root is reached. An append clears the new node's row,
// walks suffix links adding edges to the new node, and when a clone is made
// copies the target's row to the clone and redirects edges to it. Clear
// zeroes the root row; the same root-row clearing pass runs after reset,
// during which no transaction is accepted. The result register lets a
// finished result wait while the next transaction is taken.
module suffix_automaton_common_substring_core #(
  parameter int MAX_LEN  = sacs_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = sacs_pkg::ALPHABET_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sacs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sacs_pkg::out_t out_data
);

  localparam int NODE_W = $clog2(2 * MAX_LEN);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int SYM_W  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

  logic              tr_we;
  logic [NODE_W-1:0] tr_wnode;
  logic [SYM_W-1:0]  tr_wsym;
  logic [NODE_W-1:0] tr_wdata;
  logic [NODE_W-1:0] tr_rnode;
  logic [SYM_W-1:0]  tr_rsym;
  logic [NODE_W-1:0] tr_rdata;
  logic              nd_we;
  logic [NODE_W-1:0] nd_waddr;
  logic [NODE_W-1:0] nd_wlink;
  logic [LEN_W-1:0]  nd_wlen;
  logic [NODE_W-1:0] nd_raddr;
  logic [NODE_W-1:0] nd_rlink;
  logic [LEN_W-1:0]  nd_rlen;

  // Sequencer.
  sacs_ctrl #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET),
    .NODE_W   (NODE_W),
    .LEN_W    (LEN_W),
    .SYM_W    (SYM_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .tr_we     (tr_we),
    .tr_wnode  (tr_wnode),
    .tr_wsym   (tr_wsym),
    .tr_wdata  (tr_wdata),
    .tr_rnode  (tr_rnode),
    .tr_rsym   (tr_rsym),
    .tr_rdata  (tr_rdata),
    .nd_we     (nd_we),
    .nd_waddr  (nd_waddr),
    .nd_wlink  (nd_wlink),
    .nd_wlen   (nd_wlen),
    .nd_raddr  (nd_raddr),
    .nd_rlink  (nd_rlink),
    .nd_rlen   (nd_rlen)
  );

  // Transition table.
  sacs_trans_mem #(
    .NODE_W (NODE_W),
    .SYM_W  (SYM_W)
  ) u_trans_mem (
    .clk   (clk),
    .we    (tr_we),
    .wnode (tr_wnode),
    .wsym  (tr_wsym),
    .wdata (tr_wdata),
    .rnode (tr_rnode),
    .rsym  (tr_rsym),
    .rdata (tr_rdata)
  );

  // Suffix links and node lengths.
  sacs_node_mem #(
    .NODE_W (NODE_W),
    .LEN_W  (LEN_W)
  ) u_node_mem (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_waddr),
    .wlink (nd_wlink),
    .wlen  (nd_wlen),
    .raddr (nd_raddr),
    .rlink (nd_rlink),
    .rlen  (nd_rlen)
  );

endmodule
